[design/dcek_pkg.sv]
// ============================================================================
// dcek_pkg: shared types and constants of the certificate key extractor
// Holds the result record that travels from the parser to the emitter.
// ============================================================================
package dcek_pkg;

    localparam int unsigned MaxLengthBytes = 4;
    localparam int unsigned FieldsSkipped  = 5;

    localparam logic [1:0] KIND_PARAM  = 2'd0;
    localparam logic [1:0] KIND_POINT  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TAG   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_BAD_BITS  = 3'd4;
    localparam logic [2:0] ST_BAD_POINT = 3'd5;
    localparam logic [2:0] ST_TOO_LONG  = 3'd6;

    // One accepted byte produces up to four results.
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][1:0] kind;
        logic [3:0][7:0] data;
        logic [3:0][2:0] status;
    } t_group;

endpackage

[design/dcek_parser.sv]
// ============================================================================
// dcek_parser: DER tag-length-value walker
// Classifies each certificate byte and produces its group of results.
// ============================================================================
module dcek_parser #(
    parameter int unsigned MAX_LENGTH_BYTES = dcek_pkg::MaxLengthBytes,
    parameter int unsigned FIELDS_SKIPPED   = dcek_pkg::FieldsSkipped
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_cert_byte,
    input  logic             i_final_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output dcek_pkg::t_group o_group
);

    typedef enum logic [3:0] {
        PH_CERT, PH_TBS, PH_FIRST, PH_SKIP, PH_SPKI, PH_ALG, PH_AOID, PH_CURVE,
        PH_ALGREST, PH_BIT, PH_UNUSED, PH_PTFIRST, PH_POINT, PH_DONE
    } t_phase;
    typedef enum logic [1:0] {S_TAG, S_LEN1, S_LENX, S_VAL} t_step;

    t_phase      r_phase, n_phase;
    t_step       r_step, n_step;
    logic [31:0] r_pos, r_acc, n_acc;
    logic [2:0]  r_lbl, n_lbl, r_skip, n_skip;
    logic [31:0] r_cert_end, n_cert_end, r_tbs_end, n_tbs_end;
    logic [31:0] r_ki_end, n_ki_end, r_alg_end, n_alg_end, r_el_end, n_el_end;
    logic        r_fin, n_fin;
    logic [2:0]  r_err, n_err;
    logic        r_valid;
    dcek_pkg::t_group r_group, grp;
    logic        take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_group = r_group;

    logic [32:0] pos1;
    assign pos1 = {1'b0, r_pos} + 33'd1;

    always_comb begin
        logic [1:0]  pk [4];
        logic [7:0]  pd [4];
        logic [2:0]  pn;
        logic [32:0] lim, endp, plen;
        logic [31:0] acc_v;
        logic [2:0]  st;
        logic        done;
        t_phase      ph;
        n_phase = r_phase; n_step = r_step; n_acc = r_acc; n_lbl = r_lbl;
        n_skip = r_skip; n_cert_end = r_cert_end; n_tbs_end = r_tbs_end;
        n_ki_end = r_ki_end; n_alg_end = r_alg_end; n_el_end = r_el_end;
        n_fin = r_fin; n_err = r_err;
        for (int i = 0; i < 4; i++) begin
            pk[i] = dcek_pkg::KIND_POINT; pd[i] = 8'd0;
        end
        pn = 3'd0; done = 1'b0; acc_v = r_acc; endp = '0; lim = '0;
        st = dcek_pkg::ST_OK;
        plen = {1'b0, r_el_end} - {1'b0, r_pos};
        ph = r_phase;
        if (!r_fin) begin
            unique case (r_phase)
                PH_DONE: ;
                PH_ALGREST: begin
                    if (pos1 >= {1'b0, r_alg_end}) begin
                        n_phase = PH_BIT; n_step = S_TAG;
                    end
                end
                PH_UNUSED: begin
                    if (i_cert_byte != 8'h00) begin
                        n_fin = 1'b1; n_err = dcek_pkg::ST_BAD_BITS;
                    end else n_phase = PH_PTFIRST;
                end
                PH_PTFIRST: begin
                    if (plen < 33'd2 || i_cert_byte != 8'h04) begin
                        n_fin = 1'b1; n_err = dcek_pkg::ST_BAD_POINT;
                    end else if (plen > 33'd255) begin
                        n_fin = 1'b1; n_err = dcek_pkg::ST_TOO_LONG;
                    end else begin
                        pd[0] = 8'h04;
                        if (plen >= 33'd128) begin
                            pd[1] = 8'h81; pd[2] = plen[7:0]; pd[3] = i_cert_byte;
                            pn = 3'd4;
                        end else begin
                            pd[1] = plen[7:0]; pd[2] = i_cert_byte; pn = 3'd3;
                        end
                        n_phase = PH_POINT;
                    end
                end
                PH_POINT: begin
                    pd[0] = i_cert_byte; pn = 3'd1;
                    if (pos1 >= {1'b0, r_el_end}) begin
                        n_phase = PH_DONE; n_fin = 1'b1; n_err = dcek_pkg::ST_OK;
                    end
                end
                default: begin
                    if (r_step == S_TAG && r_phase == PH_FIRST &&
                        !({1'b0, r_pos} < {1'b0, r_tbs_end} && i_cert_byte == 8'hA0))
                        ph = PH_SKIP;
                    n_phase = ph;
                    unique case (ph)
                        PH_CERT: lim = 33'hFFFFFFFF;
                        PH_TBS: lim = {1'b0, r_cert_end};
                        PH_FIRST, PH_SKIP, PH_SPKI: lim = {1'b0, r_tbs_end};
                        PH_ALG, PH_BIT: lim = {1'b0, r_ki_end};
                        default: lim = {1'b0, r_alg_end};
                    endcase
                    if ({1'b0, r_pos} >= lim) begin
                        n_fin = 1'b1; n_err = dcek_pkg::ST_OVERRUN;
                    end else begin
                        case (r_step)
                            S_TAG: begin
                                if (((ph == PH_CERT || ph == PH_TBS || ph == PH_SPKI ||
                                      ph == PH_ALG) && i_cert_byte != 8'h30) ||
                                    (ph == PH_CURVE && i_cert_byte != 8'h06) ||
                                    (ph == PH_BIT && i_cert_byte != 8'h03)) begin
                                    n_fin = 1'b1; n_err = dcek_pkg::ST_BAD_TAG;
                                end else begin
                                    if (ph == PH_CURVE) begin
                                        pk[0] = dcek_pkg::KIND_PARAM;
                                        pd[0] = i_cert_byte; pn = 3'd1;
                                    end
                                    n_step = S_LEN1;
                                end
                            end
                            S_LEN1: begin
                                if (i_cert_byte[7]) begin
                                    if (i_cert_byte[6:0] == 7'd0 ||
                                        {25'd0, i_cert_byte[6:0]} > MAX_LENGTH_BYTES) begin
                                        n_fin = 1'b1; n_err = dcek_pkg::ST_BAD_LEN;
                                    end else begin
                                        if (ph == PH_CURVE) begin
                                            pk[0] = dcek_pkg::KIND_PARAM;
                                            pd[0] = i_cert_byte; pn = 3'd1;
                                        end
                                        n_lbl = i_cert_byte[2:0];
                                        n_acc = 32'd0; n_step = S_LENX;
                                    end
                                end else begin
                                    if (ph == PH_CURVE) begin
                                        pk[0] = dcek_pkg::KIND_PARAM;
                                        pd[0] = i_cert_byte; pn = 3'd1;
                                    end
                                    acc_v = {24'd0, i_cert_byte}; n_acc = acc_v; done = 1'b1;
                                end
                            end
                            S_LENX: begin
                                if (ph == PH_CURVE) begin
                                    pk[0] = dcek_pkg::KIND_PARAM;
                                    pd[0] = i_cert_byte; pn = 3'd1;
                                end
                                acc_v = {r_acc[23:0], i_cert_byte}; n_acc = acc_v;
                                n_lbl = (r_lbl != 3'd0) ? r_lbl - 3'd1 : 3'd0;
                                if (n_lbl == 3'd0) done = 1'b1;
                            end
                            default: begin
                                if (ph == PH_CURVE) begin
                                    pk[0] = dcek_pkg::KIND_PARAM;
                                    pd[0] = i_cert_byte; pn = 3'd1;
                                end
                                if (pos1 >= {1'b0, r_el_end}) begin
                                    n_step = S_TAG;
                                    if (ph == PH_SKIP) begin
                                        if ({29'd0, r_skip} + 32'd1 >= FIELDS_SKIPPED) begin
                                            n_phase = PH_SPKI; n_skip = 3'd0;
                                        end else n_skip = r_skip + 3'd1;
                                    end else if (ph == PH_AOID) n_phase = PH_CURVE;
                                    else if (ph == PH_CURVE)
                                        n_phase = (pos1 == {1'b0, r_alg_end}) ?
                                                  PH_BIT : PH_ALGREST;
                                end
                            end
                        endcase
                        if (done) begin
                            endp = pos1 + {1'b0, acc_v};
                            if (endp > lim) begin
                                n_fin = 1'b1; n_err = dcek_pkg::ST_OVERRUN;
                            end else begin
                                n_step = S_TAG;
                                case (ph)
                                    PH_CERT: begin
                                        n_cert_end = endp[31:0]; n_phase = PH_TBS;
                                    end
                                    PH_TBS: begin
                                        n_tbs_end = endp[31:0]; n_phase = PH_FIRST;
                                    end
                                    PH_SPKI: begin
                                        n_ki_end = endp[31:0]; n_phase = PH_ALG;
                                    end
                                    PH_ALG: begin
                                        n_alg_end = endp[31:0]; n_phase = PH_AOID;
                                    end
                                    PH_BIT: begin
                                        if (acc_v < 32'd2) begin
                                            n_fin = 1'b1; n_err = dcek_pkg::ST_BAD_BITS;
                                        end else begin
                                            n_el_end = endp[31:0]; n_phase = PH_UNUSED;
                                        end
                                    end
                                    default: begin
                                        n_el_end = endp[31:0];
                                        if (acc_v != 32'd0) n_step = S_VAL;
                                        else if (ph == PH_FIRST) begin
                                            n_phase = PH_SKIP; n_skip = 3'd0;
                                        end else if (ph == PH_SKIP) begin
                                            if ({29'd0, r_skip} + 32'd1 >= FIELDS_SKIPPED) begin
                                                n_phase = PH_SPKI; n_skip = 3'd0;
                                            end else n_skip = r_skip + 3'd1;
                                        end else if (ph == PH_AOID) n_phase = PH_CURVE;
                                        else if (ph == PH_CURVE)
                                            n_phase = (pos1 == {1'b0, r_alg_end}) ?
                                                      PH_BIT : PH_ALGREST;
                                    end
                                endcase
                            end
                        end
                        // A value of the first field ends the optional version.
                        if (ph == PH_FIRST && r_step == S_VAL && pos1 >= {1'b0, r_el_end}) begin
                            n_phase = PH_SKIP; n_skip = 3'd0;
                        end
                    end
                end
            endcase
        end
        grp = '0;
        if (i_final_byte) begin
            if (pos1 < {1'b0, r_cert_end}) st = dcek_pkg::ST_OVERRUN;
            else if (n_fin) st = n_err;
            else st = dcek_pkg::ST_OVERRUN;
            if (n_fin && n_err == dcek_pkg::ST_OK) begin
                if (pn > 3'd3) pn = 3'd3;
            end else pn = 3'd0;
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < pn) begin
                    grp.kind[i] = pk[i]; grp.data[i] = pd[i];
                end else if (3'(i) == pn) begin
                    grp.kind[i] = dcek_pkg::KIND_STATUS; grp.status[i] = st;
                end
            end
            grp.count = pn + 3'd1;
        end else begin
            for (int i = 0; i < 4; i++) begin
                grp.kind[i] = pk[i]; grp.data[i] = pd[i];
            end
            grp.count = pn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= (grp.count != 3'd0);
            r_group <= grp;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (!i_rst_n || (take && i_final_byte)) begin
            r_phase <= PH_CERT; r_step <= S_TAG; r_pos <= '0; r_acc <= '0;
            r_lbl <= '0; r_skip <= '0; r_cert_end <= '0; r_tbs_end <= '0;
            r_ki_end <= '0; r_alg_end <= '0; r_el_end <= '0;
            r_fin <= 1'b0; r_err <= '0;
        end else if (take) begin
            r_phase <= n_phase; r_step <= n_step; r_acc <= n_acc; r_lbl <= n_lbl;
            r_skip <= n_skip; r_cert_end <= n_cert_end; r_tbs_end <= n_tbs_end;
            r_ki_end <= n_ki_end; r_alg_end <= n_alg_end; r_el_end <= n_el_end;
            r_fin <= n_fin; r_err <= n_err;
            if (r_pos != 32'hFFFFFFFF) r_pos <= r_pos + 32'd1;
        end
    end

endmodule

[design/dcek_queue.sv]
// ============================================================================
// dcek_queue: two-entry group queue
// Decouples the parser from the result emitter.
// ============================================================================
module dcek_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dcek_pkg::t_group i_group,
    output logic             o_valid,
    input  logic             i_ready,
    output dcek_pkg::t_group o_group
);

    dcek_pkg::t_group r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_group = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) r_mem[r_wp] <= i_group;
    end

endmodule

[design/dcek_emitter.sv]
// ============================================================================
// dcek_emitter: result serializer
// Sends the results of one group one transfer at a time.
// ============================================================================
module dcek_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dcek_pkg::t_group i_group,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data,
    output logic [2:0]       o_status,
    output logic             o_run_end
);

    logic [1:0] r_idx;
    logic       last;

    assign o_valid   = i_valid;
    assign o_kind    = i_group.kind[r_idx];
    assign o_data    = i_group.data[r_idx];
    assign o_status  = i_group.status[r_idx];
    assign last      = ({1'b0, r_idx} + 3'd1 == i_group.count);
    assign o_run_end = last;
    assign o_ready   = last && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (i_valid && i_ready) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

[design/der_cert_ec_key_extractor.sv]
// ============================================================================
// der_cert_ec_key_extractor: EC public key extractor for DER certificates
// Walks an X.509 certificate byte stream and emits the curve OID and point.
// ============================================================================
// The block takes one certificate byte per transfer and accepts a new byte in
// every cycle while its output keeps up. The front parser classifies each byte
// combinationally and registers the group of up to four results it causes;
// a two-entry queue sits between it and the emitter, which sends one result
// per transfer, marking the last result of a byte with run_end. A byte that
// causes several results (the wrapped point header) therefore holds the
// output for that many transfers, and the queue lets the parser keep accepting
// meanwhile. Results pass the parser register and then the queue.
// A final status always follows the byte flagged final; on failure the
// consumer discards the parameter and point bytes already sent.
module der_cert_ec_key_extractor #(
    parameter int unsigned MAX_LENGTH_BYTES = dcek_pkg::MaxLengthBytes,
    parameter int unsigned FIELDS_SKIPPED   = dcek_pkg::FieldsSkipped
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_cert_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [2:0] o_status,
    output logic       o_run_end
);

    dcek_pkg::t_group p_group, q_group;
    logic p_valid, p_ready, q_valid, q_ready;

    dcek_parser #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
        .FIELDS_SKIPPED  (FIELDS_SKIPPED)
    ) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cert_byte(i_cert_byte), .i_final_byte(i_final_byte),
        .o_valid(p_valid), .i_ready(p_ready), .o_group(p_group)
    );

    dcek_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(p_valid), .o_ready(p_ready), .i_group(p_group),
        .o_valid(q_valid), .i_ready(q_ready), .o_group(q_group)
    );

    dcek_emitter u_emitter (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_group(q_group),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_data(o_data), .o_status(o_status),
        .o_run_end(o_run_end)
    );

endmodule
